// ===== src/stc_pkg.sv =====
// ----------------------------------------------------------------------------
// stc_pkg
// Shared constants and types of the sequencer transport clock.
// ----------------------------------------------------------------------------
package stc_pkg;

    localparam int TICKS_PER_STEP = 6;
    localparam int TICKS_PER_BAR  = 96;
    localparam int NUDGE_LIMIT    = 24;

    localparam int POS_W    = 32;           // tick position and quotient width
    localparam int DIV_W    = 16;           // divisor and remainder width
    localparam int CNT_W    = $clog2(POS_W);
    localparam int ADV_W    = 17;
    localparam int CTR_W    = 16;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;
    localparam int REQ_W    = 3;

    // register index, taken from paddr[2]
    localparam logic REG_PERIOD = 1'b0;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK   = 3'd0,
        REQ_START  = 3'd1,
        REQ_STOP   = 3'd2,
        REQ_TOGGLE = 3'd3,
        REQ_NUDGE  = 3'd4,
        REQ_CLEAR  = 3'd5
    } req_t;

endpackage

// ===== src/stc_div_lane.sv =====
// ----------------------------------------------------------------------------
// stc_div_lane
// Bit-serial restoring divider: one quotient bit per shift cycle, MSB first.
// ----------------------------------------------------------------------------
module stc_div_lane
    import stc_pkg::*;
(
    input  logic             aclk,
    input  logic             load,
    input  logic             shift,
    input  logic [POS_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic [POS_W-1:0] quotient
);

    logic [POS_W-1:0] quo_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] dvs_reg;
    logic [DIV_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[POS_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge aclk) begin
        if (load) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (shift) begin
            // remainder stays below divisor, so the top trial bit drops out
            rem_reg <= fits ? DIV_W'(trial - {1'b0, dvs_reg}) : trial[DIV_W-1:0];
            quo_reg <= {quo_reg[POS_W-2:0], fits};
        end
    end

    assign quotient = quo_reg;

endmodule

// ===== src/sequencer_transport_clock_unit.sv =====
// ----------------------------------------------------------------------------
// sequencer_transport_clock_unit
// Transport clock of a music sequencer: start/stop/toggle, nudge, position
// and step/bar/period boundary tracking.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  s_        in         s_valid / s_ready  s_req_type, s_nudge_ticks
//  m_        out        m_valid / m_ready  one result per tick request
//  apb       in         psel/penable       period_length at address 0
//
//  Non-tick requests complete when accepted. A tick is accepted, then runs
//  in six bit-serial divider lanes (old and new position by step,
//  bar and period length) in ST_DIV, and loads the result register in ST_DONE.
//  A stalled result holds in the output register; a non-tick request is
//  still accepted meanwhile, a tick waits in ST_DONE until the
//  register frees. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module sequencer_transport_clock_unit
    import stc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [REQ_W-1:0]       s_req_type,
    input  logic signed [15:0]     s_nudge_ticks,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_is_playing,
    output logic [ADV_W-1:0]       m_ticks_advanced,
    output logic [POS_W-1:0]       m_tick_position,
    output logic [POS_W-1:0]       m_step_number,
    output logic [POS_W-1:0]       m_bar_number,
    output logic [POS_W-1:0]       m_period_number,
    output logic                   m_step_hit,
    output logic                   m_bar_hit,
    output logic                   m_period_hit,

    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [DATA_W-1:0]      pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_DONE} state_t;
    typedef enum logic [1:0] {KIND_START, KIND_HOLD, KIND_ADV} kind_t;

    localparam logic signed [17:0] LIM_POS = 18'(NUDGE_LIMIT);
    localparam logic signed [17:0] LIM_NEG = -18'(NUDGE_LIMIT);
    localparam int NLANE = 6;

    // ---------------- configuration ----------------
    logic [DIV_W-1:0] period_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_PERIOD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= '0;
        end else if (cfg_wr) begin
            period_reg <= pwdata[DIV_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_PERIOD) ? {{(DATA_W-DIV_W){1'b0}}, period_reg} : '0;

    // ---------------- transport state ----------------
    logic             running_reg, running_next;
    logic             start_pend_reg, start_pend_next;
    logic             stop_pend_reg, stop_pend_next;
    logic             first_reg, first_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [CTR_W-1:0] offset_reg, offset_next;
    logic [CTR_W-1:0] extra_reg, extra_next;
    logic [CTR_W-1:0] skip_reg, skip_next;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             accept;
    logic             tick_acc;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign tick_acc = accept && (s_req_type == REQ_TICK);

    // nudge datapath
    logic signed [17:0] cur18, t18, target18, clamp18, applied18;
    logic [CTR_W-1:0]   mag;
    logic [CTR_W:0]     extra_sum, skip_sum;

    assign cur18     = 18'(signed'(offset_reg));
    assign t18       = (s_req_type == REQ_NUDGE) ? 18'(s_nudge_ticks) : -cur18;
    assign target18  = cur18 + t18;
    assign clamp18   = (target18 > LIM_POS) ? LIM_POS :
                       (target18 < LIM_NEG) ? LIM_NEG : target18;
    assign applied18 = clamp18 - cur18;
    assign mag       = applied18[17] ? CTR_W'(-applied18) : CTR_W'(applied18);
    assign extra_sum = {1'b0, extra_reg} + {1'b0, mag};
    assign skip_sum  = {1'b0, skip_reg} + {1'b0, mag};

    // tick datapath
    logic             run_eff;
    logic [ADV_W-1:0] adv;
    logic [POS_W:0]   pos_sum;
    kind_t            kind;

    assign run_eff = stop_pend_reg ? 1'b0 : running_reg;
    assign adv     = first_reg ? {1'b0, extra_reg} : {1'b0, extra_reg} + ADV_W'(1);
    assign pos_sum = {1'b0, pos_reg} + {{(POS_W+1-ADV_W){1'b0}}, adv};

    always_comb begin
        if (start_pend_reg) begin
            kind = KIND_START;
        end else if (!run_eff || (skip_reg != '0)) begin
            kind = KIND_HOLD;
        end else begin
            kind = KIND_ADV;
        end
    end

    always_comb begin
        running_next    = running_reg;
        start_pend_next = start_pend_reg;
        stop_pend_next  = stop_pend_reg;
        first_next      = first_reg;
        pos_next        = pos_reg;
        offset_next     = offset_reg;
        extra_next      = extra_reg;
        skip_next       = skip_reg;
        if (accept) begin
            case (s_req_type)
                REQ_TICK: begin
                    running_next   = run_eff;
                    stop_pend_next = 1'b0;
                    case (kind)
                        KIND_START: begin
                            running_next    = 1'b1;
                            start_pend_next = 1'b0;
                            first_next      = 1'b0;
                            pos_next        = '0;
                            offset_next     = '0;
                            extra_next      = '0;
                            skip_next       = '0;
                        end
                        KIND_HOLD: begin
                            if (run_eff) begin
                                skip_next = skip_reg - CTR_W'(1);
                            end
                        end
                        KIND_ADV: begin
                            extra_next = '0;
                            first_next = 1'b0;
                            pos_next   = pos_sum[POS_W-1:0];
                        end
                        default: ;
                    endcase
                end
                REQ_START: begin
                    start_pend_next = 1'b1;
                    stop_pend_next  = 1'b0;
                end
                REQ_STOP: begin
                    stop_pend_next  = 1'b1;
                    start_pend_next = 1'b0;
                end
                REQ_TOGGLE: begin
                    if (running_reg && !stop_pend_reg) begin
                        stop_pend_next  = 1'b1;
                        start_pend_next = 1'b0;
                    end else begin
                        start_pend_next = 1'b1;
                        stop_pend_next  = 1'b0;
                    end
                end
                REQ_NUDGE, REQ_CLEAR: begin
                    if (applied18 != '0) begin
                        offset_next = clamp18[CTR_W-1:0];
                        if (applied18[17]) begin
                            skip_next = skip_sum[CTR_W] ? '1 : skip_sum[CTR_W-1:0];
                        end else begin
                            extra_next = extra_sum[CTR_W] ? '1 : extra_sum[CTR_W-1:0];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg    <= 1'b0;
            start_pend_reg <= 1'b0;
            stop_pend_reg  <= 1'b0;
            first_reg      <= 1'b1;
            pos_reg        <= '0;
            offset_reg     <= '0;
            extra_reg      <= '0;
            skip_reg       <= '0;
        end else begin
            running_reg    <= running_next;
            start_pend_reg <= start_pend_next;
            stop_pend_reg  <= stop_pend_next;
            first_reg      <= first_next;
            pos_reg        <= pos_next;
            offset_reg     <= offset_next;
            extra_reg      <= extra_next;
            skip_reg       <= skip_next;
        end
    end

    // ---------------- result capture at accept ----------------
    kind_t            hd_kind_reg;
    logic             hd_playing_reg;
    logic             hd_first_reg;
    logic             hd_wrap_reg;
    logic [ADV_W-1:0] hd_adv_reg;

    always_ff @(posedge aclk) begin
        if (tick_acc) begin
            hd_kind_reg    <= kind;
            hd_playing_reg <= (kind == KIND_START) ? 1'b1 : run_eff;
            hd_first_reg   <= first_reg;
            hd_wrap_reg    <= pos_sum[POS_W];
            case (kind)
                KIND_START: hd_adv_reg <= ADV_W'(1);
                KIND_ADV:   hd_adv_reg <= adv;
                default:    hd_adv_reg <= '0;
            endcase
        end
    end

    // ---------------- divider lanes ----------------
    // lanes 0..2: old position by step, bar, period; lanes 3..5: new position
    logic [DIV_W-1:0] per_eff;
    logic [POS_W-1:0] lane_dividend [NLANE];
    logic [DIV_W-1:0] lane_divisor  [NLANE];
    logic [POS_W-1:0] lane_quo      [NLANE];
    logic             lane_shift;

    assign per_eff    = (period_reg == '0) ? DIV_W'(TICKS_PER_BAR) : period_reg;
    assign lane_shift = (state_reg == ST_DIV);

    genvar g;
    generate
        for (g = 0; g < NLANE; g++) begin : g_lane
            assign lane_dividend[g] = (g < 3) ? pos_reg : pos_next;
            assign lane_divisor[g]  = ((g % 3) == 0) ? DIV_W'(TICKS_PER_STEP) :
                                      ((g % 3) == 1) ? DIV_W'(TICKS_PER_BAR) : per_eff;
            stc_div_lane u_lane (
                .aclk     (aclk),
                .load     (tick_acc),
                .shift    (lane_shift),
                .dividend (lane_dividend[g]),
                .divisor  (lane_divisor[g]),
                .quotient (lane_quo[g])
            );
        end
    endgenerate

    // boundary flags from the finished quotients
    logic adv_any, is_adv, is_start;
    logic step_x, bar_x, per_x;

    assign is_adv   = (hd_kind_reg == KIND_ADV);
    assign is_start = (hd_kind_reg == KIND_START);
    assign adv_any  = (hd_adv_reg != '0) && is_adv;
    assign step_x   = adv_any && (hd_wrap_reg || (lane_quo[3] != lane_quo[0]));
    assign bar_x    = adv_any && (hd_wrap_reg || (lane_quo[4] != lane_quo[1]));
    assign per_x    = adv_any && (hd_wrap_reg || (lane_quo[5] != lane_quo[2]));

    // ---------------- sequencer and result register ----------------
    logic             m_valid_reg;
    logic             out_free;
    logic             res_load;
    logic             res_playing_reg, res_step_hit_reg, res_bar_hit_reg, res_per_hit_reg;
    logic [ADV_W-1:0] res_adv_reg;
    logic [POS_W-1:0] res_pos_reg, res_step_reg, res_bar_reg, res_per_reg;
    logic             force_hit;

    assign out_free  = !m_valid_reg || m_ready;
    assign res_load  = (state_reg == ST_DONE) && out_free;
    assign force_hit = is_start || (is_adv && hd_first_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !res_load) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (tick_acc) begin
                        state_reg <= ST_DIV;
                        cnt_reg   <= CNT_W'(POS_W - 1);
                    end
                end
                ST_DIV: begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == '0) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // hold the finished request until the result register frees
                    if (out_free) begin
                        state_reg        <= ST_IDLE;
                        m_valid_reg      <= 1'b1;
                        res_playing_reg  <= hd_playing_reg;
                        res_adv_reg      <= hd_adv_reg;
                        res_pos_reg      <= pos_reg;
                        res_step_reg     <= lane_quo[3];
                        res_bar_reg      <= is_adv ? lane_quo[4] : '0;
                        res_per_reg      <= is_adv ? lane_quo[5] : '0;
                        res_step_hit_reg <= force_hit || step_x;
                        res_bar_hit_reg  <= force_hit || bar_x;
                        res_per_hit_reg  <= force_hit || per_x;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_is_playing     = res_playing_reg;
    assign m_ticks_advanced = res_adv_reg;
    assign m_tick_position  = res_pos_reg;
    assign m_step_number    = res_step_reg;
    assign m_bar_number     = res_bar_reg;
    assign m_period_number  = res_per_reg;
    assign m_step_hit       = res_step_hit_reg;
    assign m_bar_hit        = res_bar_hit_reg;
    assign m_period_hit     = res_per_hit_reg;

endmodule

// ===== src/stc_checker.sv =====
// ----------------------------------------------------------------------------
// stc_checker
// Port-level checks of the sequencer transport clock, bound to the top level.
// ----------------------------------------------------------------------------
module stc_checker
    import stc_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic                   m_is_playing,
    input logic [ADV_W-1:0]       m_ticks_advanced,
    input logic [POS_W-1:0]       m_tick_position,
    input logic [POS_W-1:0]       m_step_number,
    input logic [POS_W-1:0]       m_bar_number,
    input logic [POS_W-1:0]       m_period_number,
    input logic                   m_step_hit,
    input logic                   m_bar_hit,
    input logic                   m_period_hit
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_hold_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_tick_position) && $stable(m_step_number))
        else $error("result payload changed while stalled");

    // a stopped transport reports no movement and no boundary
    a_stopped_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_playing |-> m_ticks_advanced == '0 && !m_step_hit &&
            !m_bar_hit && !m_period_hit && m_bar_number == '0 && m_period_number == '0)
        else $error("stopped result shows movement");

    // arriving at position zero by one tick is a start or a wrap: every boundary
    a_zero_hits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ticks_advanced == ADV_W'(1) && m_tick_position == '0 |->
            m_step_hit && m_bar_hit && m_period_hit && m_is_playing)
        else $error("missing boundary flags at position zero");

    // the advance never exceeds one plus the saturated extra count
    a_adv_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_ticks_advanced <= ADV_W'(65536))
        else $error("advance out of range");

endmodule

bind sequencer_transport_clock_unit stc_checker u_stc_checker (.*);
